FILE: rtl/exlex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer package
// Shared widths, token kind codes and the result word layout.
// ----------------------------------------------------------------------------
package exlex_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int OUT_POS_W     = 16;
    localparam int CHAR_W        = 8;
    localparam int KIND_W        = 4;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 40;
    localparam int M_PAD_W       = M_TDATA_W - KIND_W - 2 * OUT_POS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_END    = 4'd0,
        KIND_SYMBOL = 4'd1,
        KIND_NUMBER = 4'd2,
        KIND_PLUS   = 4'd3,
        KIND_MINUS  = 4'd4,
        KIND_TIMES  = 4'd5,
        KIND_DIVIDE = 4'd6,
        KIND_LPAREN = 4'd7,
        KIND_RPAREN = 4'd8,
        KIND_POWER  = 4'd9,
        KIND_BAD    = 4'd10
    } kind_t;

    // packed low to high: kind, start_pos, length, last
    typedef struct packed {
        logic                 last;
        logic [OUT_POS_W-1:0] length;
        logic [OUT_POS_W-1:0] start_pos;
        kind_t                kind;
    } lex_result_t;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_HIGH   = 8'h80;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LOW_E  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_UP_E   = 8'h45;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_symch(input logic [CHAR_W-1:0] c);
        return (c == CH_UNDER) || is_alpha(c) || is_digit(c);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/expression_lexer_core.sv
`default_nettype none
// A result word is registered and appears on m_ in the cycle after the byte is accepted.
// Throughput: one byte per cycle while m_tready is high; a byte that yields
// two tokens holds s_tready low while the two-word output queue drains.
// Reset (aresetn low, synchronous): mode idle, positions and lengths zero,
// output queue empty.
// ----------------------------------------------------------------------------
// Expression lexer core
// Byte-stream tokenizer for arithmetic expressions with a two-word result
// queue; mode, token start and position update in one pass per byte.
// ----------------------------------------------------------------------------
module expression_lexer_core #(
    parameter int POS_WIDTH = exlex_pkg::POS_WIDTH_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [exlex_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] char_in
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [3:0] kind, [19:4] start_pos, [35:20] length, [39:36] zero
    output logic [exlex_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast    // last_of_run
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_SYM  = 3'd1,
        MODE_INT  = 3'd2,
        MODE_FRAC = 3'd3,
        MODE_EXPE = 3'd4,
        MODE_EXPD = 3'd5,
        MODE_BAD  = 3'd6,
        MODE_STAR = 3'd7
    } mode_t;

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? v : v + POS_WIDTH'(1);
    endfunction

    mode_t                     mode_reg, mode_next, mode_a;
    logic [POS_WIDTH-1:0]      tok_start_reg, tok_start_next;
    logic [POS_WIDTH-1:0]      cur_pos_reg, cur_pos_next;
    logic [POS_WIDTH-1:0]      tok_len_reg, tok_len_next;
    logic [1:0]                cnt_reg, cnt_next;
    exlex_pkg::lex_result_t    q0_reg, q0_next, q1_reg, q1_next;

    logic [exlex_pkg::CHAR_W-1:0] c;
    logic                         s_accept, m_pop, take;
    logic                         prev_v, char_v;
    exlex_pkg::lex_result_t       prev_r, char_r;
    logic [exlex_pkg::OUT_POS_W-1:0] start_o, len_o, pos_o;

    assign c        = s_tdata;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_pop    = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tdata  = {{exlex_pkg::M_PAD_W{1'b0}}, q0_reg.length, q0_reg.start_pos,
                       q0_reg.kind};
    assign m_tlast  = q0_reg.last;

    assign start_o = exlex_pkg::OUT_POS_W'(tok_start_reg);
    assign len_o   = exlex_pkg::OUT_POS_W'(tok_len_reg);
    assign pos_o   = exlex_pkg::OUT_POS_W'(cur_pos_reg);

    // lexer step
    always_comb begin
        take           = 1'b0;
        mode_a         = mode_reg;
        prev_v         = 1'b0;
        prev_r         = '0;
        char_v         = 1'b0;
        char_r         = '0;
        tok_len_next   = tok_len_reg;
        tok_start_next = tok_start_reg;
        cur_pos_next   = sat_inc(cur_pos_reg);

        unique case (mode_reg)
            MODE_SYM: take = exlex_pkg::is_symch(c);
            MODE_INT: begin
                if (c == exlex_pkg::CH_POINT) begin
                    mode_a = MODE_FRAC;
                    take   = 1'b1;
                end else if ((c == exlex_pkg::CH_LOW_E) || (c == exlex_pkg::CH_UP_E)) begin
                    mode_a = MODE_EXPE;
                    take   = 1'b1;
                end else begin
                    take = exlex_pkg::is_digit(c);
                end
            end
            MODE_FRAC: begin
                if ((c == exlex_pkg::CH_LOW_E) || (c == exlex_pkg::CH_UP_E)) begin
                    mode_a = MODE_EXPE;
                    take   = 1'b1;
                end else begin
                    take = exlex_pkg::is_digit(c);
                end
            end
            MODE_EXPE: begin
                if ((c == exlex_pkg::CH_PLUS) || (c == exlex_pkg::CH_MINUS) ||
                    exlex_pkg::is_digit(c)) begin
                    mode_a = MODE_EXPD;
                    take   = 1'b1;
                end
            end
            MODE_EXPD: take = exlex_pkg::is_digit(c);
            MODE_BAD:  take = (c & exlex_pkg::CH_HIGH) != '0;
            MODE_STAR: begin
                prev_v           = 1'b1;
                prev_r.start_pos = start_o;
                mode_a           = MODE_IDLE;
                if (c == exlex_pkg::CH_STAR) begin
                    prev_r.kind   = exlex_pkg::KIND_POWER;
                    prev_r.length = exlex_pkg::OUT_POS_W'(2);
                    take          = 1'b1;
                end else begin
                    prev_r.kind   = exlex_pkg::KIND_TIMES;
                    prev_r.length = exlex_pkg::OUT_POS_W'(1);
                end
            end
            MODE_IDLE: mode_a = MODE_IDLE;
        endcase

        mode_next = mode_a;

        if (take) begin
            if (mode_a != MODE_IDLE) begin
                tok_len_next = sat_inc(tok_len_reg);
            end
        end else begin
            // flush the pending token
            prev_r.start_pos = start_o;
            prev_r.length    = len_o;
            unique case (mode_a)
                MODE_SYM: begin
                    prev_v      = 1'b1;
                    prev_r.kind = exlex_pkg::KIND_SYMBOL;
                end
                MODE_INT, MODE_FRAC, MODE_EXPE, MODE_EXPD: begin
                    prev_v      = 1'b1;
                    prev_r.kind = exlex_pkg::KIND_NUMBER;
                end
                MODE_BAD: begin
                    prev_v      = 1'b1;
                    prev_r.kind = exlex_pkg::KIND_BAD;
                end
                MODE_IDLE, MODE_STAR: ;
            endcase
            mode_next        = MODE_IDLE;
            char_r.start_pos = pos_o;
            char_r.length    = exlex_pkg::OUT_POS_W'(1);

            priority if (c == exlex_pkg::CH_NUL) begin
                char_v        = 1'b1;
                char_r.kind   = exlex_pkg::KIND_END;
                char_r.length = '0;
                cur_pos_next  = '0;
            end else if (exlex_pkg::is_space(c)) begin
                mode_next = MODE_IDLE;
            end else if (c == exlex_pkg::CH_STAR || c == exlex_pkg::CH_POINT ||
                         exlex_pkg::is_symch(c)) begin
                tok_start_next = cur_pos_reg;
                tok_len_next   = POS_WIDTH'(1);
                if (c == exlex_pkg::CH_STAR)         mode_next = MODE_STAR;
                else if (c == exlex_pkg::CH_POINT)   mode_next = MODE_FRAC;
                else if (exlex_pkg::is_digit(c))     mode_next = MODE_INT;
                else                                 mode_next = MODE_SYM;
            end else if (c == exlex_pkg::CH_PLUS) begin
                char_v      = 1'b1;
                char_r.kind = exlex_pkg::KIND_PLUS;
            end else if (c == exlex_pkg::CH_MINUS) begin
                char_v      = 1'b1;
                char_r.kind = exlex_pkg::KIND_MINUS;
            end else if (c == exlex_pkg::CH_SLASH) begin
                char_v      = 1'b1;
                char_r.kind = exlex_pkg::KIND_DIVIDE;
            end else if (c == exlex_pkg::CH_LPAREN) begin
                char_v      = 1'b1;
                char_r.kind = exlex_pkg::KIND_LPAREN;
            end else if (c == exlex_pkg::CH_RPAREN) begin
                char_v      = 1'b1;
                char_r.kind = exlex_pkg::KIND_RPAREN;
            end else begin
                tok_start_next = cur_pos_reg;
                tok_len_next   = POS_WIDTH'(1);
                mode_next      = MODE_BAD;
            end
        end
        prev_r.last = !char_v;
        char_r.last = 1'b1;
    end

    // output queue; an accept only happens when it will be empty
    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (s_accept) begin
            if (prev_v) begin
                q0_next  = prev_r;
                q1_next  = char_r;
                cnt_next = char_v ? 2'd2 : 2'd1;
            end else begin
                q0_next  = char_r;
                cnt_next = char_v ? 2'd1 : 2'd0;
            end
        end else if (m_pop) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            tok_start_reg <= '0;
            cur_pos_reg   <= '0;
            tok_len_reg   <= '0;
            cnt_reg       <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_accept) begin
                mode_reg      <= mode_next;
                tok_start_reg <= tok_start_next;
                cur_pos_reg   <= cur_pos_next;
                tok_len_reg   <= tok_len_next;
            end
        end
    end

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_tready)
        else $error("input taken with full result queue");

    a_pair_head_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !q0_reg.last)
        else $error("first word of a pair marked last");

    a_nul_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tdata == exlex_pkg::CH_NUL)) |=>
            ((cur_pos_reg == '0) && (mode_reg == MODE_IDLE) && m_tvalid))
        else $error("end of string did not restart lexer");

    a_pending_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_IDLE) |-> (tok_len_reg != '0))
        else $error("pending token with zero length");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Expression lexer core testbench
// Feeds byte strings into the lexer and checks every token word against a
// built-in tokenizer model: directed strings for each token kind and corner,
// then random expressions and noise with one long symbol string, sent with no
// idling on either side, midway through; random stalls on both sides and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import exlex_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_BYTES  = 1450;
    localparam int LONG_RUN    = 150;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 36;

    localparam string DIGITS   = "0123456789";
    localparam string SYM_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string SYM_BODY =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string OPS      = "+-*/()";
    localparam string JUNK     = "!#$%&;:<=>?@[]^{|}~,'";

    typedef enum logic [3:0] {
        LX_IDLE, LX_SYM, LX_INT, LX_FRAC, LX_EXPE, LX_EXPD, LX_BAD, LX_STAR
    } lex_mode_e;

    typedef struct packed {
        kind_t                kind;
        logic [OUT_POS_W-1:0] start_pos;
        logic [OUT_POS_W-1:0] length;
        logic                 last;
    } token_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    expression_lexer_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    logic [CHAR_W-1:0] char_q[$];
    token_t            tok_expect_q[$];
    int                bytes_sent = 0;
    int                err_cnt    = 0;
    int                cyc_cnt    = 0;
    int                hold_left  = 0;
    bit                hold_done  = 1'b0;
    int                long_lo    = -1;
    int                long_hi    = -1;
    logic              calm;

    // no idling while the long string goes through
    assign calm = (bytes_sent >= long_lo) && (bytes_sent < long_hi);

    // tokenizer state
    lex_mode_e            lx_mode  = LX_IDLE;
    logic [OUT_POS_W-1:0] lx_start = '0;
    logic [OUT_POS_W-1:0] lx_pos   = '0;
    logic [OUT_POS_W-1:0] lx_len   = '0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic ch_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic ch_letter(input logic [CHAR_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic ch_space(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [OUT_POS_W-1:0] sat_inc(input logic [OUT_POS_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void open_tok(input lex_mode_e m);
        lx_mode  = m;
        lx_start = lx_pos;
        lx_len   = OUT_POS_W'(1);
    endfunction

    // advance the tokenizer by one byte and queue the token words it yields
    function automatic void lex_byte(input logic [CHAR_W-1:0] c);
        token_t run[$];
        logic   take;
        take = 1'b0;
        case (lx_mode)
            LX_SYM: take = (c == CH_UNDER) || ch_letter(c) || ch_digit(c);
            LX_INT: begin
                if (c == CH_POINT) begin
                    lx_mode = LX_FRAC;
                    take = 1'b1;
                end else if (c == CH_LOW_E || c == CH_UP_E) begin
                    lx_mode = LX_EXPE;
                    take = 1'b1;
                end else begin
                    take = ch_digit(c);
                end
            end
            LX_FRAC: begin
                if (c == CH_LOW_E || c == CH_UP_E) begin
                    lx_mode = LX_EXPE;
                    take = 1'b1;
                end else begin
                    take = ch_digit(c);
                end
            end
            LX_EXPE: begin
                if (c == CH_PLUS || c == CH_MINUS || ch_digit(c)) begin
                    lx_mode = LX_EXPD;
                    take = 1'b1;
                end
            end
            LX_EXPD: take = ch_digit(c);
            LX_BAD:  take = c[7];
            LX_STAR: begin
                if (c == CH_STAR) begin
                    run.push_back(token_t'{KIND_POWER, lx_start, 16'd2, 1'b0});
                    take = 1'b1;
                end else begin
                    run.push_back(token_t'{KIND_TIMES, lx_start, 16'd1, 1'b0});
                end
                lx_mode = LX_IDLE;
            end
            default: lx_mode = LX_IDLE;
        endcase

        if (take) begin
            if (lx_mode != LX_IDLE) lx_len = sat_inc(lx_len);
        end else begin
            case (lx_mode)
                LX_SYM: run.push_back(token_t'{KIND_SYMBOL, lx_start, lx_len, 1'b0});
                LX_INT, LX_FRAC, LX_EXPE, LX_EXPD:
                    run.push_back(token_t'{KIND_NUMBER, lx_start, lx_len, 1'b0});
                LX_BAD: run.push_back(token_t'{KIND_BAD, lx_start, lx_len, 1'b0});
                default: ;
            endcase
            lx_mode = LX_IDLE;
            if (c == CH_NUL) begin
                run.push_back(token_t'{KIND_END, lx_pos, 16'd0, 1'b0});
            end else if (ch_space(c)) begin
            end else if (c == CH_UNDER || ch_letter(c)) begin
                open_tok(LX_SYM);
            end else if (ch_digit(c)) begin
                open_tok(LX_INT);
            end else if (c == CH_POINT) begin
                open_tok(LX_FRAC);
            end else if (c == CH_STAR) begin
                open_tok(LX_STAR);
            end else if (c == CH_PLUS) begin
                run.push_back(token_t'{KIND_PLUS, lx_pos, 16'd1, 1'b0});
            end else if (c == CH_MINUS) begin
                run.push_back(token_t'{KIND_MINUS, lx_pos, 16'd1, 1'b0});
            end else if (c == CH_SLASH) begin
                run.push_back(token_t'{KIND_DIVIDE, lx_pos, 16'd1, 1'b0});
            end else if (c == CH_LPAREN) begin
                run.push_back(token_t'{KIND_LPAREN, lx_pos, 16'd1, 1'b0});
            end else if (c == CH_RPAREN) begin
                run.push_back(token_t'{KIND_RPAREN, lx_pos, 16'd1, 1'b0});
            end else begin
                open_tok(LX_BAD);
            end
        end

        lx_pos = (c == CH_NUL) ? '0 : sat_inc(lx_pos);
        if (run.size() > 0) run[run.size()-1].last = 1'b1;
        foreach (run[i]) tok_expect_q.push_back(run[i]);
    endfunction

    function automatic void put_char(input logic [CHAR_W-1:0] c);
        char_q.push_back(c);
    endfunction

    function automatic void push_str(input string s);
        foreach (s[i]) put_char(s[i]);
    endfunction

    function automatic logic [CHAR_W-1:0] pick(input string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [CHAR_W-1:0] ws_byte();
        return $urandom_range(0, 1) ? CH_SPACE : CHAR_W'($urandom_range(9, 13));
    endfunction

    // byte source
    always @(posedge aclk) begin : tx_ctl
        int nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt = bytes_sent;
            if (s_tvalid && s_tready) begin
                lex_byte(s_tdata);
                nxt++;
            end
            bytes_sent <= nxt;
            if (s_tvalid && !s_tready) begin
                // hold the offered word
            end else if (nxt < char_q.size() &&
                         (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= char_q[nxt];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // token sink, with one long hold-off to back the core up
    always @(posedge aclk) begin : rx_ctl
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && bytes_sent >= HOLD_AT && !calm) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin : tok_check
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tok_expect_q.size() == 0) begin
                $error("unexpected token word %h last %b", m_tdata, m_tlast);
                err_cnt++;
            end else begin
                want = tok_expect_q.pop_front();
                if (m_tdata[KIND_W-1:0] !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tdata[KIND_W-1:0]);
                    err_cnt++;
                end
                if (m_tdata[KIND_W +: OUT_POS_W] !== want.start_pos) begin
                    $error("start_pos: expected %0d, got %0d", want.start_pos,
                           m_tdata[KIND_W +: OUT_POS_W]);
                    err_cnt++;
                end
                if (m_tdata[KIND_W+OUT_POS_W +: OUT_POS_W] !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length,
                           m_tdata[KIND_W+OUT_POS_W +: OUT_POS_W]);
                    err_cnt++;
                end
                if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0) begin
                    $error("pad: expected 0, got %h", m_tdata[M_TDATA_W-1 -: M_PAD_W]);
                    err_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_run: expected %b, got %b", want.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : run_ctl
        int ntok;

        // directed: every operator but plus, power vs times, incomplete exponents,
        // high-bit bytes in a bad token, end flushing a pending bad token, number and star
        push_str("_9 1.5E+7e**3*()/-");
        put_char(8'h80);
        put_char(8'hFF);
        put_char("!");
        put_char(CH_NUL);
        push_str("9e)4e+");
        put_char(CH_NUL);
        put_char(CH_STAR);
        put_char(CH_NUL);
        put_char(CH_NUL);

        while (char_q.size() < RAND_BYTES) begin
            if (long_lo < 0 && char_q.size() >= RAND_BYTES / 2) begin
                // one long symbol, sent with no idling
                long_lo = char_q.size();
                repeat (LONG_RUN) char_q.push_back("a");
                char_q.push_back(CH_SPACE);
                char_q.push_back(CH_PLUS);
                char_q.push_back(CH_NUL);
                long_hi = char_q.size();
            end
            if ($urandom_range(0, 99) < 80) begin
                ntok = $urandom_range(1, 12);
                repeat (ntok) begin
                    case ($urandom_range(0, 9))
                        0, 1: begin
                            put_char(pick(SYM_HEAD));
                            repeat ($urandom_range(0, 5)) put_char(pick(SYM_BODY));
                        end
                        2, 3: begin
                            if ($urandom_range(0, 3) == 0) begin
                                put_char(CH_POINT);
                                repeat ($urandom_range(0, 3)) put_char(pick(DIGITS));
                            end else begin
                                repeat ($urandom_range(1, 4)) put_char(pick(DIGITS));
                                if ($urandom_range(0, 1)) begin
                                    put_char(CH_POINT);
                                    repeat ($urandom_range(0, 3)) put_char(pick(DIGITS));
                                end
                            end
                            if ($urandom_range(0, 1)) begin
                                put_char(pick("eE"));
                                if ($urandom_range(0, 1)) put_char(pick("+-"));
                                repeat ($urandom_range(0, 3)) put_char(pick(DIGITS));
                            end
                        end
                        4, 5: put_char(pick(OPS));
                        6: push_str("**");
                        7: begin
                            case ($urandom_range(0, 2))
                                0: put_char(CHAR_W'($urandom_range(128, 255)));
                                1: put_char(pick(JUNK));
                                default: put_char(CHAR_W'($urandom_range(1, 8)));
                            endcase
                            repeat ($urandom_range(0, 3))
                                put_char(CHAR_W'($urandom_range(128, 255)));
                        end
                        default: put_char(ws_byte());
                    endcase
                    if ($urandom_range(0, 1)) put_char(ws_byte());
                end
            end else begin
                repeat ($urandom_range(1, 8)) put_char(CHAR_W'($urandom_range(0, 255)));
            end
            put_char(CH_NUL);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_sent < char_q.size() || tok_expect_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
